@@ rtl/sst_pkg.sv @@
// Shared types, token codes and keyword tables for the source tokenizer.
package sst_pkg;

  localparam int KeywordMaxLenDef = 6;
  localparam int PositionBitsDef  = 16;
  localparam int OffsetBitsDef    = 24;

  localparam int NumResults = 3;
  localparam int NumKeywords = 11;
  localparam int KwTextLen   = 6;

  localparam logic [5:0] K_IDENT   = 6'd11;
  localparam logic [5:0] K_NUMBER  = 6'd12;
  localparam logic [5:0] K_STRING  = 6'd13;
  localparam logic [5:0] K_LPAREN  = 6'd14;
  localparam logic [5:0] K_RPAREN  = 6'd15;
  localparam logic [5:0] K_LBRACE  = 6'd16;
  localparam logic [5:0] K_RBRACE  = 6'd17;
  localparam logic [5:0] K_LBRACK  = 6'd18;
  localparam logic [5:0] K_RBRACK  = 6'd19;
  localparam logic [5:0] K_COMMA   = 6'd20;
  localparam logic [5:0] K_COLON   = 6'd21;
  localparam logic [5:0] K_SEMI    = 6'd22;
  localparam logic [5:0] K_DOT     = 6'd23;
  localparam logic [5:0] K_PLUS    = 6'd24;
  localparam logic [5:0] K_MINUS   = 6'd25;
  localparam logic [5:0] K_STAR    = 6'd26;
  localparam logic [5:0] K_SLASH   = 6'd27;
  localparam logic [5:0] K_PERCENT = 6'd28;
  localparam logic [5:0] K_BANG    = 6'd29;
  localparam logic [5:0] K_BANGEQ  = 6'd30;
  localparam logic [5:0] K_LT      = 6'd31;
  localparam logic [5:0] K_LTEQ    = 6'd32;
  localparam logic [5:0] K_GT      = 6'd33;
  localparam logic [5:0] K_GTEQ    = 6'd34;
  localparam logic [5:0] K_EQ      = 6'd35;
  localparam logic [5:0] K_EQEQ    = 6'd36;
  localparam logic [5:0] K_ARROW   = 6'd37;
  localparam logic [5:0] K_AND     = 6'd38;
  localparam logic [5:0] K_OR      = 6'd39;
  localparam logic [5:0] K_ERROR   = 6'd40;
  localparam logic [5:0] K_END     = 6'd41;
  localparam logic [5:0] K_STRCHAR = 6'd42;

  localparam logic [1:0] E_NONE    = 2'd0;
  localparam logic [1:0] E_BADCHAR = 2'd1;
  localparam logic [1:0] E_UNTERM  = 2'd2;

  localparam logic [7:0] KW_TEXT [NumKeywords][KwTextLen] = '{
    '{"l", "e", "t", 8'h0, 8'h0, 8'h0},
    '{"f", "n", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"r", "e", "t", "u", "r", "n"},
    '{"i", "f", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"e", "l", "s", "e", 8'h0, 8'h0},
    '{"w", "h", "i", "l", "e", 8'h0},
    '{"f", "o", "r", 8'h0, 8'h0, 8'h0},
    '{"i", "n", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"t", "r", "u", "e", 8'h0, 8'h0},
    '{"f", "a", "l", "s", "e", 8'h0},
    '{"n", "u", "l", "l", 8'h0, 8'h0}
  };
  localparam logic [2:0] KW_LEN [NumKeywords] = '{3'd3, 3'd2, 3'd6, 3'd2, 3'd4, 3'd5,
                                                  3'd3, 3'd2, 3'd4, 3'd5, 3'd4};

  typedef struct packed {
    logic [5:0]  kind;
    logic [7:0]  value;
    logic [1:0]  err;
    logic [15:0] line;
    logic [15:0] col;
    logic [23:0] start;
    logic [15:0] len;
    logic        last;
  } res_t;

  typedef struct packed {
    res_t [NumResults-1:0] res;
    logic [1:0]            count;
  } res_set_t;

endpackage

@@ rtl/script_source_tokenizer_top.sv @@
// Top level of the streaming source tokenizer.
// One source byte per transaction; the lexer state and the token results for that byte are
// computed combinationally and captured in a result register, so a byte can be taken every
// cycle as long as each byte yields at most one result and the consumer keeps up. A byte that
// yields two or three results (a token closed by a punctuation byte, or the end token) holds
// the input while the result register drains the extra results.
module script_source_tokenizer_top #(
  parameter int KEYWORD_MAX_LEN = sst_pkg::KeywordMaxLenDef,
  parameter int POSITION_BITS   = sst_pkg::PositionBitsDef,
  parameter int OFFSET_BITS     = sst_pkg::OffsetBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_source_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  token_kind_o,
  output logic [7:0]  value_byte_o,
  output logic [1:0]  error_code_o,
  output logic [15:0] line_number_o,
  output logic [15:0] column_number_o,
  output logic [23:0] start_offset_o,
  output logic [15:0] token_length_o,
  output logic        last_result_o
);
  import sst_pkg::*;

  res_set_t set;
  res_t     res;
  logic     accept;

  assign accept = in_valid_i && in_ready_o;

  sst_lexer #(
    .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN),
    .POSITION_BITS  (POSITION_BITS),
    .OFFSET_BITS    (OFFSET_BITS)
  ) u_lexer (
    .clk_i,
    .rst_ni,
    .char_byte_i,
    .has_byte_i,
    .end_of_source_i,
    .accept_i (accept),
    .results_o(set)
  );

  sst_out_buf u_out_buf (
    .clk_i,
    .rst_ni,
    .push_i     (accept),
    .set_i      (set),
    .free_o     (in_ready_o),
    .out_valid_o,
    .out_ready_i,
    .res_o      (res)
  );

  assign token_kind_o    = res.kind;
  assign value_byte_o    = res.value;
  assign error_code_o    = res.err;
  assign line_number_o   = res.line;
  assign column_number_o = res.col;
  assign start_offset_o  = res.start;
  assign token_length_o  = res.len;
  assign last_result_o   = res.last;

endmodule

@@ rtl/sst_lexer.sv @@
// Lexer state and single-pass next-state logic producing up to three results per byte.
module sst_lexer #(
  parameter int KEYWORD_MAX_LEN = sst_pkg::KeywordMaxLenDef,
  parameter int POSITION_BITS   = sst_pkg::PositionBitsDef,
  parameter int OFFSET_BITS     = sst_pkg::OffsetBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        char_byte_i,
  input  logic              has_byte_i,
  input  logic              end_of_source_i,
  input  logic              accept_i,
  output sst_pkg::res_set_t results_o
);
  import sst_pkg::*;

  localparam int IdxW = $clog2(KEYWORD_MAX_LEN);
  localparam logic [15:0] LenMax = 16'hFFFF;
  localparam logic [POSITION_BITS-1:0] PosMax = '1;

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_BANG, M_LT, M_GT, M_EQ, M_AMP, M_BAR,
    M_LCOM, M_BCOM, M_BSTAR, M_NUM, M_IDENT, M_STR, M_ESC
  } mode_e;

  typedef struct packed {
    logic [OFFSET_BITS-1:0]   boff;
    logic [15:0]              wlen;
    logic [POSITION_BITS-1:0] line;
    logic [POSITION_BITS-1:0] col;
  } pos_t;

  mode_e                  mode_q, mode_d;
  pos_t                   pos_q, pos_d;
  logic [OFFSET_BITS-1:0] tstart_q, tstart_d;
  logic                   dot_q, dot_d;
  logic                   ended_q, ended_d;
  logic [7:0]             wbuf_q [KEYWORD_MAX_LEN];
  logic                   wb_we;
  logic [IdxW-1:0]        wb_idx;
  res_set_t               set_d;

  function automatic pos_t consume(pos_t p, logic [7:0] c);
    pos_t r;
    r = p;
    r.boff = p.boff + 1'b1;
    if (p.wlen != LenMax) r.wlen = p.wlen + 16'd1;
    if (c == 8'h0A) begin
      if (p.line != PosMax) r.line = p.line + 1'b1;
      r.col = POSITION_BITS'(1);
    end else if (p.col != PosMax) begin
      r.col = p.col + 1'b1;
    end
    return r;
  endfunction

  function automatic res_t mk(logic [5:0] kind, logic [7:0] val, logic [1:0] err, pos_t p,
                              logic [OFFSET_BITS-1:0] start, logic [15:0] len);
    res_t r;
    r.kind  = kind;
    r.value = val;
    r.err   = err;
    r.line  = 16'(p.line);
    r.col   = 16'(p.col);
    r.start = 24'(start);
    r.len   = len;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [5:0] word_kind(logic [15:0] wlen, logic [7:0] buf_w [KEYWORD_MAX_LEN]);
    logic [5:0] k;
    logic       m;
    k = K_IDENT;
    for (int i = NumKeywords - 1; i >= 0; i--) begin
      m = (wlen == 16'(KW_LEN[i]));
      for (int j = 0; j < KwTextLen; j++) begin
        if (j < int'(KW_LEN[i]) && buf_w[j] != KW_TEXT[i][j]) m = 1'b0;
      end
      if (m) k = 6'(i);
    end
    return k;
  endfunction

  always_comb begin
    logic       restart;
    logic [7:0] c;
    logic [7:0] d;
    logic [OFFSET_BITS-1:0] at;
    logic [1:0] n;
    logic [5:0] sk;
    logic       single;

    c        = char_byte_i;
    mode_d   = mode_q;
    pos_d    = pos_q;
    tstart_d = tstart_q;
    dot_d    = dot_q;
    ended_d  = ended_q;
    wb_we    = 1'b0;
    wb_idx   = '0;
    set_d    = '0;
    n        = '0;
    restart  = 1'b0;
    d        = c;
    at       = pos_q.boff;
    sk       = K_PLUS;
    single   = 1'b0;

    if (!ended_q) begin
      if (has_byte_i) begin
        unique case (mode_q)
          M_SLASH: begin
            if (c == "/") begin
              pos_d = consume(pos_d, c); mode_d = M_LCOM;
            end else if (c == "*") begin
              pos_d = consume(pos_d, c); mode_d = M_BCOM;
            end else begin
              set_d.res[n] = mk(K_SLASH, '0, E_NONE, pos_d, tstart_d, pos_d.wlen);
              n = n + 2'd1; mode_d = M_IDLE; restart = 1'b1;
            end
          end
          M_BANG, M_LT, M_GT: begin
            if (c == "=") begin
              pos_d = consume(pos_d, c);
              set_d.res[n] = mk(mode_q == M_BANG ? K_BANGEQ : (mode_q == M_LT ? K_LTEQ : K_GTEQ),
                                '0, E_NONE, pos_d, tstart_d, pos_d.wlen);
              n = n + 2'd1;
            end else begin
              set_d.res[n] = mk(mode_q == M_BANG ? K_BANG : (mode_q == M_LT ? K_LT : K_GT),
                                '0, E_NONE, pos_d, tstart_d, pos_d.wlen);
              n = n + 2'd1; restart = 1'b1;
            end
            mode_d = M_IDLE;
          end
          M_EQ: begin
            if (c == ">" || c == "=") begin
              pos_d = consume(pos_d, c);
              set_d.res[n] = mk(c == ">" ? K_ARROW : K_EQEQ, '0, E_NONE, pos_d, tstart_d,
                                pos_d.wlen);
            end else begin
              set_d.res[n] = mk(K_EQ, '0, E_NONE, pos_d, tstart_d, pos_d.wlen);
              restart = 1'b1;
            end
            n = n + 2'd1; mode_d = M_IDLE;
          end
          M_AMP, M_BAR: begin
            if ((mode_q == M_AMP && c == "&") || (mode_q == M_BAR && c == "|")) begin
              pos_d = consume(pos_d, c);
              set_d.res[n] = mk(mode_q == M_AMP ? K_AND : K_OR, '0, E_NONE, pos_d, tstart_d,
                                pos_d.wlen);
            end else begin
              set_d.res[n] = mk(K_ERROR, mode_q == M_AMP ? 8'h26 : 8'h7C, E_BADCHAR, pos_d,
                                tstart_d, pos_d.wlen);
              restart = 1'b1;
            end
            n = n + 2'd1; mode_d = M_IDLE;
          end
          M_LCOM: begin
            pos_d = consume(pos_d, c);
            if (c == 8'h0A) mode_d = M_IDLE;
          end
          M_BCOM: begin
            pos_d = consume(pos_d, c);
            if (c == "*") mode_d = M_BSTAR;
          end
          M_BSTAR: begin
            pos_d = consume(pos_d, c);
            if (c == "/") mode_d = M_IDLE;
            else if (c != "*") mode_d = M_BCOM;
          end
          M_NUM: begin
            if (is_digit(c) || (c == "." && !dot_q)) begin
              if (c == ".") dot_d = 1'b1;
              pos_d = consume(pos_d, c);
            end else begin
              set_d.res[n] = mk(K_NUMBER, '0, E_NONE, pos_d, tstart_d, pos_d.wlen);
              n = n + 2'd1; mode_d = M_IDLE; restart = 1'b1;
            end
          end
          M_IDENT: begin
            if (is_alpha(c) || is_digit(c) || c == "_") begin
              if (pos_d.wlen < 16'(KEYWORD_MAX_LEN)) begin
                wb_we = 1'b1; wb_idx = pos_d.wlen[IdxW-1:0];
              end
              pos_d = consume(pos_d, c);
            end else begin
              set_d.res[n] = mk(word_kind(pos_d.wlen, wbuf_q), '0, E_NONE, pos_d, tstart_d,
                                pos_d.wlen);
              n = n + 2'd1; mode_d = M_IDLE; restart = 1'b1;
            end
          end
          M_STR: begin
            at = pos_d.boff;
            pos_d = consume(pos_d, c);
            if (c == 8'h22) begin
              mode_d = M_IDLE;
              set_d.res[n] = mk(K_STRING, '0, E_NONE, pos_d, tstart_d, pos_d.wlen);
              n = n + 2'd1;
            end else if (c == 8'h5C) begin
              mode_d = M_ESC;
            end else begin
              set_d.res[n] = mk(K_STRCHAR, c, E_NONE, pos_d, at, 16'd1);
              n = n + 2'd1;
            end
          end
          M_ESC: begin
            at = pos_d.boff - 1'b1;
            d = (c == "n") ? 8'h0A : ((c == "t") ? 8'h09 : c);
            pos_d = consume(pos_d, c);
            mode_d = M_STR;
            set_d.res[n] = mk(K_STRCHAR, d, E_NONE, pos_d, at, 16'd2);
            n = n + 2'd1;
          end
          default: begin
            mode_d = M_IDLE; restart = 1'b1;
          end
        endcase

        if (restart) begin
          tstart_d   = pos_d.boff;
          pos_d.wlen = '0;
          pos_d      = consume(pos_d, c);
          single     = 1'b1;
          unique case (c)
            "(": sk = K_LPAREN;
            ")": sk = K_RPAREN;
            "{": sk = K_LBRACE;
            "}": sk = K_RBRACE;
            "[": sk = K_LBRACK;
            "]": sk = K_RBRACK;
            ",": sk = K_COMMA;
            ":": sk = K_COLON;
            ";": sk = K_SEMI;
            ".": sk = K_DOT;
            "+": sk = K_PLUS;
            "-": sk = K_MINUS;
            "*": sk = K_STAR;
            "%": sk = K_PERCENT;
            default: single = 1'b0;
          endcase
          if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
            // whitespace: nothing to emit
          end else if (single) begin
            set_d.res[n] = mk(sk, '0, E_NONE, pos_d, tstart_d, pos_d.wlen);
            n = n + 2'd1;
          end else if (c == "/") mode_d = M_SLASH;
          else if (c == "!") mode_d = M_BANG;
          else if (c == "<") mode_d = M_LT;
          else if (c == ">") mode_d = M_GT;
          else if (c == "=") mode_d = M_EQ;
          else if (c == "&") mode_d = M_AMP;
          else if (c == "|") mode_d = M_BAR;
          else if (c == 8'h22) mode_d = M_STR;
          else if (is_digit(c)) begin
            mode_d = M_NUM; dot_d = 1'b0;
          end else if (is_alpha(c) || c == "_") begin
            mode_d = M_IDENT; wb_we = 1'b1; wb_idx = '0;
          end else begin
            set_d.res[n] = mk(K_ERROR, c, E_BADCHAR, pos_d, tstart_d, pos_d.wlen);
            n = n + 2'd1;
          end
        end
      end

      if (end_of_source_i) begin
        unique case (mode_d)
          M_SLASH: begin set_d.res[n] = mk(K_SLASH, '0, E_NONE, pos_d, tstart_d, pos_d.wlen); n = n + 2'd1; end
          M_BANG:  begin set_d.res[n] = mk(K_BANG, '0, E_NONE, pos_d, tstart_d, pos_d.wlen); n = n + 2'd1; end
          M_LT:    begin set_d.res[n] = mk(K_LT, '0, E_NONE, pos_d, tstart_d, pos_d.wlen); n = n + 2'd1; end
          M_GT:    begin set_d.res[n] = mk(K_GT, '0, E_NONE, pos_d, tstart_d, pos_d.wlen); n = n + 2'd1; end
          M_EQ:    begin set_d.res[n] = mk(K_EQ, '0, E_NONE, pos_d, tstart_d, pos_d.wlen); n = n + 2'd1; end
          M_AMP:   begin set_d.res[n] = mk(K_ERROR, 8'h26, E_BADCHAR, pos_d, tstart_d, pos_d.wlen); n = n + 2'd1; end
          M_BAR:   begin set_d.res[n] = mk(K_ERROR, 8'h7C, E_BADCHAR, pos_d, tstart_d, pos_d.wlen); n = n + 2'd1; end
          M_NUM:   begin set_d.res[n] = mk(K_NUMBER, '0, E_NONE, pos_d, tstart_d, pos_d.wlen); n = n + 2'd1; end
          M_IDENT: begin
            // the byte of this transaction may have just landed in the buffer
            set_d.res[n] = mk(K_IDENT, '0, E_NONE, pos_d, tstart_d, pos_d.wlen);
            n = n + 2'd1;
          end
          M_STR, M_ESC: begin
            set_d.res[n] = mk(K_ERROR, '0, E_UNTERM, pos_d, tstart_d, pos_d.wlen);
            n = n + 2'd1;
          end
          default: ;
        endcase
        mode_d = M_IDLE;
        set_d.res[n] = mk(K_END, '0, E_NONE, pos_d, pos_d.boff, 16'd0);
        n = n + 2'd1;
        ended_d = 1'b1;
      end
      if (n != 2'd0) set_d.res[n-2'd1].last = 1'b1;
    end
    set_d.count = n;
  end

  // Keyword lookup on an identifier flushed by the end of source sees the buffer including this byte.
  logic [7:0] wbuf_view [KEYWORD_MAX_LEN];
  always_comb begin
    for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
      wbuf_view[i] = (wb_we && wb_idx == IdxW'(i)) ? char_byte_i : wbuf_q[i];
    end
  end

  always_comb begin
    results_o = set_d;
    for (int i = 0; i < NumResults; i++) begin
      if (end_of_source_i && set_d.res[i].kind == K_IDENT && set_d.res[i].start == 24'(tstart_d)
          && 2'(i) + 2'd2 == set_d.count && mode_q != M_IDLE && has_byte_i == 1'b0) begin
        results_o.res[i].kind = word_kind(pos_d.wlen, wbuf_view);
      end else if (end_of_source_i && set_d.res[i].kind == K_IDENT
                   && 2'(i) + 2'd2 == set_d.count) begin
        results_o.res[i].kind = word_kind(pos_d.wlen, wbuf_view);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      pos_q    <= '{boff: '0, wlen: '0, line: POSITION_BITS'(1), col: POSITION_BITS'(1)};
      tstart_q <= '0;
      dot_q    <= 1'b0;
      ended_q  <= 1'b0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      tstart_q <= tstart_d;
      dot_q    <= dot_d;
      ended_q  <= ended_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && wb_we) wbuf_q[wb_idx] <= char_byte_i;
  end

endmodule

@@ rtl/sst_out_buf.sv @@
// Result register holding one transaction's results and draining them one per cycle while the consumer is ready.
module sst_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sst_pkg::res_set_t set_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sst_pkg::res_t     res_o
);
  import sst_pkg::*;

  res_t [NumResults-1:0] slot_q;
  logic [1:0]            cnt_q, cnt_d;
  logic [1:0]            idx_q, idx_d;
  logic                  pop;

  assign out_valid_o = idx_q < cnt_q;
  assign pop         = out_valid_o && out_ready_i;
  assign free_o      = !out_valid_o || (pop && (idx_q + 2'd1 == cnt_q));
  assign res_o       = slot_q[idx_q];

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (push_i) begin
      cnt_d = set_i.count;
      idx_d = '0;
    end else if (pop) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q <= set_i.res;
  end

endmodule

@@ rtl/sst_checker.sv @@
// Port-level checks for the tokenizer, bound to the top level.
module sst_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [5:0]  token_kind_o,
  input logic [15:0] line_number_o,
  input logic [15:0] column_number_o,
  input logic [23:0] start_offset_o,
  input logic        last_result_o
);
  import sst_pkg::*;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(start_offset_o))
    else $error("result changed while stalled");

  a_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> line_number_o != 16'd0 && column_number_o != 16'd0)
    else $error("line or column zero");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == K_END |-> last_result_o)
    else $error("end token not last result");

endmodule

bind script_source_tokenizer_top sst_checker u_sst_checker (
  .clk_i,
  .rst_ni,
  .out_valid_o,
  .out_ready_i,
  .token_kind_o,
  .line_number_o,
  .column_number_o,
  .start_offset_o,
  .last_result_o
);
